/* sv/dprt_pkg.sv */
// ----------------------------------------------------------------------------
// Digit prefix route table package
// Shared widths, codes, entry layout and the prefix mask function.
// ----------------------------------------------------------------------------
`default_nettype none

package dprt_pkg;

   localparam int ADDR_W     = 60;
   localparam int CMD_W      = 2;
   localparam int COUNT_W    = 5;
   localparam int LEN_W      = 4;
   localparam int DEV_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int DIGIT_W    = 4;
   localparam int ADDR_DIGITS = ADDR_W / DIGIT_W;

   localparam int DEF_TABLE_ENTRIES = 32;
   localparam int DEF_MAX_DIGITS    = 15;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 2'd0,
      CMD_DELETE   = 2'd1,
      CMD_LOOKUP   = 2'd2,
      CMD_DEV_DOWN = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BAD  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   // One row of the table, valid bit included.
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] digits;
      logic [LEN_W-1:0]  length;
      logic [DEV_W-1:0]  device;
   } entry_type;

   // Result of comparing one row against the item being worked on.
   typedef struct packed {
      logic len_eq;
      logic dev_eq;
      logic digits_eq;
   } cmp_res_type;

   // Mask covering the leading n digits, first digit in the top nibble.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] n);
      logic [ADDR_W-1:0] mask;
      mask = '0;
      for (int d = 0; d < ADDR_DIGITS; d++) begin
         if (LEN_W'(d) < n) begin
            mask[ADDR_W-1-DIGIT_W*d -: DIGIT_W] = {DIGIT_W{1'b1}};
         end
      end
      return mask;
   endfunction

endpackage : dprt_pkg

`default_nettype wire

/* sv/dprt_if.sv */
// ----------------------------------------------------------------------------
// Digit prefix route table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dprt_req_if;
   logic                          valid;
   logic                          ready;
   logic [dprt_pkg::CMD_W-1:0]    command;
   logic [dprt_pkg::ADDR_W-1:0]   dest_address;
   logic [dprt_pkg::COUNT_W-1:0]  digit_count;
   logic [dprt_pkg::DEV_W-1:0]    device_id;

   modport source (output valid, command, dest_address, digit_count, device_id,
                   input ready);
   modport sink   (input valid, command, dest_address, digit_count, device_id,
                   output ready);
endinterface : dprt_req_if

interface dprt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dprt_pkg::STATUS_W-1:0]  status;
   logic                           route_found;
   logic [dprt_pkg::DEV_W-1:0]     route_device;

   modport source (output valid, status, route_found, route_device, input ready);
   modport sink   (input valid, status, route_found, route_device, output ready);
endinterface : dprt_rsp_if

`default_nettype wire

/* sv/dprt_table.sv */
// ----------------------------------------------------------------------------
// Route table storage
// Single write port, single registered read port memory of table rows.
// ----------------------------------------------------------------------------
`default_nettype none

module dprt_table #(
   parameter int ENTRIES = dprt_pkg::DEF_TABLE_ENTRIES,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [IDX_W-1:0]    wr_addr,
   input  wire dprt_pkg::entry_type wr_data,
   input  wire logic                rd_en,
   input  wire logic [IDX_W-1:0]    rd_addr,
   output dprt_pkg::entry_type      rd_data
);
   import dprt_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : dprt_table

`default_nettype wire

/* sv/dprt_cmp.sv */
// ----------------------------------------------------------------------------
// Route table compare unit
// Masked prefix, length and device comparison of one row against the item.
// ----------------------------------------------------------------------------
`default_nettype none

module dprt_cmp (
   input  wire logic [dprt_pkg::ADDR_W-1:0] key_addr,
   input  wire logic [dprt_pkg::LEN_W-1:0]  key_len,
   input  wire logic [dprt_pkg::DEV_W-1:0]  key_dev,
   input  wire logic                        use_entry_len,
   input  wire dprt_pkg::entry_type         entry,
   output dprt_pkg::cmp_res_type            result
);
   import dprt_pkg::*;

   logic [LEN_W-1:0]  mask_len;
   logic [ADDR_W-1:0] mask;

   // A lookup masks with the stored length; add and delete use the item's.
   assign mask_len = use_entry_len ? entry.length : key_len;
   assign mask     = prefix_mask(mask_len);

   always_comb begin
      result.len_eq    = (entry.length == key_len);
      result.dev_eq    = (entry.device == key_dev);
      result.digits_eq = ((entry.digits & mask) == (key_addr & mask));
   end

endmodule : dprt_cmp

`default_nettype wire

/* sv/digit_prefix_route_table_unit.sv */
// ----------------------------------------------------------------------------
// Digit prefix route table unit
// Longest-prefix route table over decimal digit addresses with add, delete,
// lookup and device-down commands, served by a sequential table walk.
// ----------------------------------------------------------------------------
// Each request item is a command against a table of TABLE_ENTRIES rows. The
// unit walks every row once through a single memory read port and a single
// shared compare unit, one row per cycle, and takes no new item until the
// walk is over and its response has been loaded. An add writes its new row
// in the commit state after the walk, whereas delete and device-down clear
// rows during the walk itself. After reset the unit runs a clearing pass,
// writing one empty row per cycle, and holds req.ready low until it has
// finished. One response item is produced for every request item, in
// order. The response sits in an output register, so a new request can be
// taken while the previous response still waits for rsp.ready; the unit
// then waits in the reply state only if that response is still unclaimed
// when the next one is ready.
// Status is ok, bad (add or delete with length above MAX_DIGITS, duplicate
// add, or delete that finds nothing) or full (add with no free row).
// route_found and route_device are only non-zero for a lookup that matched.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_prefix_route_table_unit #(
   parameter int TABLE_ENTRIES = dprt_pkg::DEF_TABLE_ENTRIES,
   parameter int MAX_DIGITS    = dprt_pkg::DEF_MAX_DIGITS
) (
   input wire logic  clock,
   input wire logic  reset,
   dprt_req_if.sink  req,
   dprt_rsp_if.source rsp
);
   import dprt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // Sequencer state.
   state_type state_ff, state_in;

   // Captured item.
   command_type       cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              len_bad_ff;
   logic [DEV_W-1:0]  dev_ff;

   // Walk control: cnt_ff addresses the next row to read, rd_tag_ff names
   // the row whose data is on the read port this cycle.
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_live_ff, rd_live_in;
   logic [IDX_W-1:0] rd_tag_ff;

   // Accumulated walk results.
   logic             dup_ff, dup_in;
   logic             slot_found_ff, slot_found_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             hit_ff, hit_in;
   logic             found_ff, found_in;
   logic [LEN_W-1:0] best_ff, best_in;
   logic [DEV_W-1:0] rdev_ff, rdev_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_found_ff;
   logic [DEV_W-1:0]    rsp_device_ff;

   // Memory and compare unit connections.
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   cmp_res_type      cmp;

   logic       req_take;
   logic       rsp_load;
   logic       walk_done;
   status_type status_now;

   dprt_table #(
      .ENTRIES (TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dprt_cmp u_cmp (
      .key_addr      (addr_ff),
      .key_len       (len_ff),
      .key_dev       (dev_ff),
      .use_entry_len (cmd_ff == CMD_LOOKUP),
      .entry         (rd_data),
      .result        (cmp)
   );

   assign req_take  = (state_ff == ST_IDLE) && req.valid;
   assign walk_done = (cnt_ff == CNT_W'(TABLE_ENTRIES));
   assign rsp_load  = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp.ready);

   // Final status of the item, valid once the walk and any commit are over.
   always_comb begin
      status_now = STATUS_OK;
      case (cmd_ff)
         CMD_ADD: begin
            if (len_bad_ff || dup_ff) begin
               status_now = STATUS_BAD;
            end else if (!slot_found_ff) begin
               status_now = STATUS_FULL;
            end
         end
         CMD_DELETE: begin
            status_now = hit_ff ? STATUS_OK : STATUS_BAD;
         end
         default: begin
            status_now = STATUS_OK;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CNT_W'(TABLE_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The last row is processed in the cycle that leaves the walk.
            if (walk_done && rd_live_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Sequencer outputs: memory ports, counter and accumulators.
   always_comb begin
      req.ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cnt_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = rd_tag_ff;
      wr_data       = rd_data;
      wr_data.valid = 1'b0;
      cnt_in        = cnt_ff;
      rd_live_in    = 1'b0;
      dup_in        = dup_ff;
      slot_found_in = slot_found_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      rdev_in       = rdev_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
            wr_data = '0;
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            req.ready     = 1'b1;
            cnt_in        = '0;
            dup_in        = 1'b0;
            slot_found_in = 1'b0;
            slot_in       = '0;
            hit_in        = 1'b0;
            found_in      = 1'b0;
            best_in       = '0;
            rdev_in       = '0;
         end
         ST_SCAN: begin
            if (!walk_done) begin
               rd_en      = 1'b1;
               rd_live_in = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
            end
            if (rd_live_ff) begin
               case (cmd_ff)
                  CMD_ADD: begin
                     if (rd_data.valid) begin
                        if (cmp.len_eq && cmp.digits_eq) begin
                           dup_in = 1'b1;
                        end
                     end else if (!slot_found_ff) begin
                        slot_found_in = 1'b1;
                        slot_in       = rd_tag_ff;
                     end
                  end
                  CMD_DELETE: begin
                     // Only the first matching row goes.
                     if (!len_bad_ff && !hit_ff && rd_data.valid && cmp.len_eq &&
                         cmp.dev_eq && cmp.digits_eq) begin
                        wr_en  = 1'b1;
                        hit_in = 1'b1;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (rd_data.valid && cmp.digits_eq &&
                         (!found_ff || (rd_data.length > best_ff))) begin
                        found_in = 1'b1;
                        best_in  = rd_data.length;
                        rdev_in  = rd_data.device;
                     end
                  end
                  default: begin
                     if (rd_data.valid && cmp.dev_eq) begin
                        wr_en = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_COMMIT: begin
            if (cmd_ff == CMD_ADD && !len_bad_ff && !dup_ff && slot_found_ff) begin
               wr_en          = 1'b1;
               wr_addr        = slot_ff;
               wr_data.valid  = 1'b1;
               wr_data.digits = addr_ff & prefix_mask(len_ff);
               wr_data.length = len_ff;
               wr_data.device = dev_ff;
            end
         end
         ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // Response handshake: load replaces, a taken item empties the register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff     <= rd_addr;
      dup_ff        <= dup_in;
      slot_found_ff <= slot_found_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      rdev_ff       <= rdev_in;
      if (req_take) begin
         cmd_ff     <= command_type'(req.command);
         addr_ff    <= req.dest_address;
         len_ff     <= req.digit_count[LEN_W-1:0];
         len_bad_ff <= (req.digit_count > COUNT_W'(MAX_DIGITS));
         dev_ff     <= req.device_id;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_now;
         rsp_found_ff  <= found_ff;
         rsp_device_ff <= rdev_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.route_found  = rsp_found_ff;
   assign rsp.route_device = rsp_device_ff;

endmodule : digit_prefix_route_table_unit

`default_nettype wire
